// ----- hw/rtl/wrs_pkg.sv -----
package wrs_pkg;

  localparam int FUNC_W   = 1;
  localparam int IDX_W    = 10;
  localparam int WGT_W    = 16;
  localparam int RAND_W   = 32;
  localparam int CFG_W    = 11;
  localparam int DIV_CW   = $clog2(RAND_W);

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_DRAW  = 1'b1;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 11'd1024;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_WALK,
    ST_FIN
  } state_t;

endpackage

// ----- hw/rtl/weighted_random_select.sv -----
// Roulette-wheel selection over a table of MAX_ENTRIES weights.
// Input channel (in_valid/in_ready): func selects a weight write or a draw.
// A write stores weight at entry_index and gives no result. A draw
// gives one result item (selected_index, empty_res) on the
// output channel (out_valid/out_ready).
// Config channel (cfg_valid/cfg_ready, cfg_data) sets active_entries; it is
// always ready. The user must write it only while the block is idle;
// the block itself does not enforce this. A draw first sums the weights
// in one pass over the table memory, then runs a bit-serial restoring
// modulo unit, one step per random bit, then makes a second pass over the
// memory that subtracts weights until the entry is found, and last loads
// the output register. Both passes use the single read port of the memory.
// The block is not ready while a draw is in progress.
// After reset the block clears the weight memory, one entry a cycle, and
// accepts no item meanwhile. active_entries resets to 1024. A result waits
// in the output register while out_ready is low; the block goes on
// accepting items, and a later draw holds in its last step until the
// waiting result has been taken.
module weighted_random_select #(
  parameter int MAX_ENTRIES = 1024,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [wrs_pkg::FUNC_W-1:0]   func,
  input  logic [wrs_pkg::IDX_W-1:0]    entry_index,
  input  logic [wrs_pkg::WGT_W-1:0]    weight,
  input  logic [wrs_pkg::RAND_W-1:0]   random_word,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wrs_pkg::IDX_W-1:0]    selected_index,
  output logic                         empty_res,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [wrs_pkg::CFG_W-1:0]    cfg_data
);
  import wrs_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CW = AW + 1;
  localparam int TW = WEIGHT_BITS + AW;

  logic [WEIGHT_BITS-1:0] mem [MAX_ENTRIES];
  logic [WEIGHT_BITS-1:0] rd_data;
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [WEIGHT_BITS-1:0] mem_wdata;

  state_t               state, state_next;
  logic [CW-1:0]        cnt, cnt_next;
  logic                 pend, pend_next;
  logic [AW-1:0]        pidx, pidx_next;
  logic [TW-1:0]        total, total_next;
  logic [TW-1:0]        rem, rem_next;
  logic [RAND_W-1:0]    rshift, rshift_next;
  logic [DIV_CW-1:0]    dcnt, dcnt_next;
  logic [AW-1:0]        res_idx, res_idx_next;
  logic                 res_empty, res_empty_next;
  logic                 out_valid_next;
  logic [IDX_W-1:0]     selected_index_next;
  logic                 empty_res_next;
  logic [CFG_W-1:0]     active_entries;
  logic [CW-1:0]        n_act;
  logic [TW:0]          div_sh;
  logic [TW:0]          div_sub;
  logic [TW-1:0]        rd_ext;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_entries <= ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      active_entries <= cfg_data;
    end
  end

  always_comb begin
    if (32'(active_entries) > 32'(MAX_ENTRIES)) begin
      n_act = CW'(MAX_ENTRIES);
    end else begin
      n_act = CW'(active_entries);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[cnt[AW-1:0]];
  end

  assign rd_ext  = TW'(rd_data);
  assign div_sh  = {rem, rshift[RAND_W-1]};
  assign div_sub = div_sh - {1'b0, total};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cnt       <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pend      <= pend_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pidx           <= pidx_next;
    total          <= total_next;
    rem            <= rem_next;
    rshift         <= rshift_next;
    dcnt           <= dcnt_next;
    res_idx        <= res_idx_next;
    res_empty      <= res_empty_next;
    selected_index <= selected_index_next;
    empty_res      <= empty_res_next;
  end

  always_comb begin
    state_next          = state;
    cnt_next            = cnt;
    pend_next           = 1'b0;
    pidx_next           = pidx;
    total_next          = total;
    rem_next            = rem;
    rshift_next         = rshift;
    dcnt_next           = dcnt;
    res_idx_next        = res_idx;
    res_empty_next      = res_empty;
    out_valid_next      = out_valid && !out_ready;
    selected_index_next = selected_index;
    empty_res_next      = empty_res;
    in_ready            = 1'b0;
    mem_we              = 1'b0;
    mem_waddr           = AW'(entry_index);
    mem_wdata           = WEIGHT_BITS'(weight);

    case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[AW-1:0];
        mem_wdata = '0;
        cnt_next  = cnt + 1'b1;
        if (cnt == CW'(MAX_ENTRIES - 1)) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func == FUNC_WRITE) begin
            mem_we = (32'(entry_index) < 32'(MAX_ENTRIES));
          end else begin
            rshift_next = random_word;
            total_next  = '0;
            cnt_next    = '0;
            state_next  = ST_SUM;
          end
        end
      end

      ST_SUM: begin
        if (cnt < n_act) begin
          cnt_next  = cnt + 1'b1;
          pend_next = 1'b1;
        end
        if (pend) begin
          total_next = total + rd_ext;
        end
        if (cnt == n_act && !pend) begin
          if (total == '0) begin
            res_idx_next   = '0;
            res_empty_next = 1'b1;
            state_next     = ST_FIN;
          end else begin
            rem_next   = '0;
            dcnt_next  = '0;
            state_next = ST_DIV;
          end
        end
      end

      ST_DIV: begin
        // restoring remainder step, one random bit per cycle
        if (!div_sub[TW]) begin
          rem_next = div_sub[TW-1:0];
        end else begin
          rem_next = div_sh[TW-1:0];
        end
        rshift_next = rshift << 1;
        dcnt_next   = dcnt + 1'b1;
        if (dcnt == DIV_CW'(RAND_W - 1)) begin
          cnt_next   = '0;
          state_next = ST_WALK;
        end
      end

      ST_WALK: begin
        if (cnt < n_act) begin
          cnt_next  = cnt + 1'b1;
          pend_next = 1'b1;
          pidx_next = cnt[AW-1:0];
        end
        if (pend) begin
          if (rem < rd_ext) begin
            res_idx_next   = pidx;
            res_empty_next = 1'b0;
            pend_next      = 1'b0;
            state_next     = ST_FIN;
          end else begin
            rem_next = rem - rd_ext;
          end
        end else if (cnt == n_act) begin
          res_idx_next   = '0;
          res_empty_next = 1'b0;
          state_next     = ST_FIN;
        end
      end

      ST_FIN: begin
        if (!out_valid || out_ready) begin
          out_valid_next      = 1'b1;
          selected_index_next = IDX_W'(res_idx);
          empty_res_next      = res_empty;
          state_next          = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
